/* rtl/uoa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uoa_pkg - obstacle avoidance shared definitions
// Field widths, stream packing offsets, timing limits, mode and command codes,
// and the structs passed between the obstacle avoidance modules.
// ----------------------------------------------------------------------------
package uoa_pkg;

  // distance width of the sensor readings
  localparam int DIST_BITS = 12;
  localparam int TIME_W    = 32;
  localparam int REG_DIST_W = 12;
  localparam int PWM_W      = 10;
  localparam int DUTY_W     = 12;
  localparam int CMD_W      = 3;
  localparam int MODE_W     = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CORR_W     = 8;
  localparam int NUM_ENT    = 3;
  localparam int CNT_W      = 2;

  // compare width that holds any distance or register plus one carry bit
  localparam int CMP_W = ((DIST_BITS > REG_DIST_W) ? DIST_BITS : REG_DIST_W) + 1;

  // input stream packing, lowest bit first
  localparam int OFS_NOW   = 0;
  localparam int OFS_AUTO  = OFS_NOW + TIME_W;
  localparam int OFS_FRONT = OFS_AUTO + 1;
  localparam int OFS_LEFT  = OFS_FRONT + DIST_BITS;
  localparam int OFS_RIGHT = OFS_LEFT + DIST_BITS;
  localparam int OFS_FOK   = OFS_RIGHT + DIST_BITS;
  localparam int OFS_LOK   = OFS_FOK + 1;
  localparam int OFS_ROK   = OFS_LOK + 1;
  localparam int OFS_FST   = OFS_ROK + 1;
  localparam int OFS_LST   = OFS_FST + TIME_W;
  localparam int OFS_RST   = OFS_LST + TIME_W;
  localparam int IN_BITS   = OFS_RST + TIME_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // output stream packing, lowest bit first
  localparam int OFS_CMD   = 0;
  localparam int OFS_LDUTY = OFS_CMD + CMD_W;
  localparam int OFS_RDUTY = OFS_LDUTY + DUTY_W;
  localparam int OFS_MODE  = OFS_RDUTY + DUTY_W;
  localparam int OUT_BITS  = OFS_MODE + MODE_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // timing limits in ms
  localparam logic [TIME_W-1:0] STALE_MS    = 32'd100;
  localparam logic [TIME_W-1:0] COOLDOWN_MS = 32'd1500;
  localparam logic [TIME_W-1:0] PAUSE_MS    = 32'd300;
  localparam logic [TIME_W-1:0] REVERSE_MS  = 32'd500;
  localparam logic [TIME_W-1:0] TURN_MIN_MS = 32'd300;
  localparam logic [TIME_W-1:0] TURN_MAX_MS = 32'd1500;

  // wall-centering limits in mm
  localparam int DEADBAND_MM = 15;
  localparam int MAX_CORR    = 110;

  // drive modes
  localparam logic [MODE_W-1:0] M_FWD   = 3'd0;
  localparam logic [MODE_W-1:0] M_PAUSE = 3'd1;
  localparam logic [MODE_W-1:0] M_REV   = 3'd2;
  localparam logic [MODE_W-1:0] M_PL    = 3'd3;
  localparam logic [MODE_W-1:0] M_PR    = 3'd4;

  // motor commands
  localparam logic [CMD_W-1:0] CMD_STOP = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FWD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BACK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PR   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIFF = 3'd5;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FRONT_STOP   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRONT_CLEAR  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SIDE_OPEN    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SIDE_BLOCKED = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_JUNC_MARGIN  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_PWM    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_TURN_PWM     = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_REVERSE_PWM  = 3'd7;

  typedef logic [DIST_BITS-1:0]        dist_t;
  typedef logic [REG_DIST_W-1:0]       rdist_t;
  typedef logic [PWM_W-1:0]            pwm_t;
  typedef logic [TIME_W-1:0]           ms_t;
  typedef logic [CMP_W-1:0]            cmp_t;
  typedef logic signed [DIST_BITS:0]   err_t;
  typedef logic signed [CORR_W-1:0]    corr_t;
  typedef logic signed [DUTY_W-1:0]    duty_t;

  typedef struct packed {
    ms_t   right_stamp_ms;
    ms_t   left_stamp_ms;
    ms_t   front_stamp_ms;
    logic  right_ok;
    logic  left_ok;
    logic  front_ok;
    dist_t right_mm;
    dist_t left_mm;
    dist_t front_mm;
    logic  auto_enabled;
    ms_t   now_ms;
  } in_t;

  typedef struct packed {
    rdist_t fwd_stop_dist;
    rdist_t fwd_clear_dist;
    rdist_t junc_open_dist;
    rdist_t side_block_dist;
    rdist_t junction_margin_mm;
    pwm_t   drive_pwm;
    pwm_t   turn_pwm;
    pwm_t   reverse_pwm;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    ms_t               mode_start_ms;
    ms_t               last_junction_ms;
    logic              prefer_left;
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    duty_t            left_duty;
    duty_t            right_duty;
  } ent_t;

  // one tick's worth of commands
  typedef struct packed {
    ent_t [NUM_ENT-1:0] ents;
    logic [CNT_W-1:0]   cnt;
    logic [MODE_W-1:0]  mode;
  } run_t;

  function automatic ent_t mk_ent(input logic [CMD_W-1:0] cmd, input duty_t l,
                                  input duty_t r);
    ent_t e;
    e.cmd        = cmd;
    e.left_duty  = l;
    e.right_duty = r;
    return e;
  endfunction

endpackage
`default_nettype wire

/* rtl/uoa_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uoa_cfg - configuration registers
// Write-only register file holding thresholds and duty values.
// ----------------------------------------------------------------------------
module uoa_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [uoa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [uoa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output uoa_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fwd_stop_dist      <= uoa_pkg::rdist_t'(250);
      cfg.fwd_clear_dist     <= uoa_pkg::rdist_t'(400);
      cfg.junc_open_dist     <= uoa_pkg::rdist_t'(500);
      cfg.side_block_dist    <= uoa_pkg::rdist_t'(200);
      cfg.junction_margin_mm <= uoa_pkg::rdist_t'(200);
      cfg.drive_pwm          <= uoa_pkg::pwm_t'(500);
      cfg.turn_pwm           <= uoa_pkg::pwm_t'(500);
      cfg.reverse_pwm        <= uoa_pkg::pwm_t'(400);
    end else if (cfg_we) begin
      case (cfg_addr)
        uoa_pkg::REG_FRONT_STOP:   cfg.fwd_stop_dist      <= cfg_wdata[uoa_pkg::REG_DIST_W-1:0];
        uoa_pkg::REG_FRONT_CLEAR:  cfg.fwd_clear_dist     <= cfg_wdata[uoa_pkg::REG_DIST_W-1:0];
        uoa_pkg::REG_SIDE_OPEN:    cfg.junc_open_dist     <= cfg_wdata[uoa_pkg::REG_DIST_W-1:0];
        uoa_pkg::REG_SIDE_BLOCKED: cfg.side_block_dist    <= cfg_wdata[uoa_pkg::REG_DIST_W-1:0];
        uoa_pkg::REG_JUNC_MARGIN:  cfg.junction_margin_mm <= cfg_wdata[uoa_pkg::REG_DIST_W-1:0];
        uoa_pkg::REG_DRIVE_PWM:    cfg.drive_pwm          <= cfg_wdata[uoa_pkg::PWM_W-1:0];
        uoa_pkg::REG_TURN_PWM:     cfg.turn_pwm           <= cfg_wdata[uoa_pkg::PWM_W-1:0];
        uoa_pkg::REG_REVERSE_PWM:  cfg.reverse_pwm        <= cfg_wdata[uoa_pkg::PWM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/uoa_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uoa_step - per-tick decision logic
// Freshness checks, mode transitions and up to three motor commands for one
// control tick, from the registered tick and the current state.
// ----------------------------------------------------------------------------
module uoa_step (
  input  wire uoa_pkg::in_t    tick,
  input  wire uoa_pkg::cfg_t   cfg,
  input  wire uoa_pkg::state_t st,
  output uoa_pkg::state_t      st_next,
  output uoa_pkg::run_t        run
);

  logic            fv, lv, rv;
  logic            cool, choose_left, lb, rb, turn_done;
  uoa_pkg::ms_t    el;
  uoa_pkg::cmp_t   front_c, left_c, right_c, fm;
  uoa_pkg::err_t   err;
  uoa_pkg::corr_t  corr;
  uoa_pkg::duty_t  tp, dp, rp, zero_d;
  uoa_pkg::ent_t   stop_e, pl_e, pr_e, back_e;

  // a reading is fresh when flagged valid and at most STALE_MS old
  assign fv = tick.front_ok && ((tick.now_ms - tick.front_stamp_ms) <= uoa_pkg::STALE_MS);
  assign lv = tick.left_ok  && ((tick.now_ms - tick.left_stamp_ms)  <= uoa_pkg::STALE_MS);
  assign rv = tick.right_ok && ((tick.now_ms - tick.right_stamp_ms) <= uoa_pkg::STALE_MS);

  assign el   = tick.now_ms - st.mode_start_ms;
  assign cool = (tick.now_ms - st.last_junction_ms) >= uoa_pkg::COOLDOWN_MS;

  assign front_c = uoa_pkg::cmp_t'(tick.front_mm);
  assign left_c  = uoa_pkg::cmp_t'(tick.left_mm);
  assign right_c = uoa_pkg::cmp_t'(tick.right_mm);
  assign fm      = front_c + uoa_pkg::cmp_t'(cfg.junction_margin_mm);

  assign choose_left = (lv && rv) ? (left_c >= right_c) : lv;
  assign lb = !lv || (left_c  < uoa_pkg::cmp_t'(cfg.side_block_dist));
  assign rb = !rv || (right_c < uoa_pkg::cmp_t'(cfg.side_block_dist));

  assign turn_done = ((el >= uoa_pkg::TURN_MIN_MS) &&
                      (front_c >= uoa_pkg::cmp_t'(cfg.fwd_clear_dist))) ||
                     (el >= uoa_pkg::TURN_MAX_MS);

  assign tp     = uoa_pkg::duty_t'({2'b00, cfg.turn_pwm});
  assign dp     = uoa_pkg::duty_t'({2'b00, cfg.drive_pwm});
  assign rp     = uoa_pkg::duty_t'({2'b00, cfg.reverse_pwm});
  assign zero_d = '0;

  assign stop_e = uoa_pkg::mk_ent(uoa_pkg::CMD_STOP, zero_d, zero_d);
  assign pl_e   = uoa_pkg::mk_ent(uoa_pkg::CMD_PL, tp, tp);
  assign pr_e   = uoa_pkg::mk_ent(uoa_pkg::CMD_PR, tp, tp);
  assign back_e = uoa_pkg::mk_ent(uoa_pkg::CMD_BACK, rp, rp);

  // wall-centering: deadband then clamp
  assign err = uoa_pkg::err_t'({1'b0, tick.right_mm}) - uoa_pkg::err_t'({1'b0, tick.left_mm});

  always_comb begin
    if (err > uoa_pkg::MAX_CORR) begin
      corr = uoa_pkg::corr_t'(uoa_pkg::MAX_CORR);
    end else if (err < -uoa_pkg::MAX_CORR) begin
      corr = uoa_pkg::corr_t'(-uoa_pkg::MAX_CORR);
    end else if ((err > uoa_pkg::DEADBAND_MM) || (err < -uoa_pkg::DEADBAND_MM)) begin
      corr = uoa_pkg::corr_t'(err);
    end else begin
      corr = '0;
    end
  end

  always_comb begin
    st_next  = st;
    run.ents = '0;
    run.cnt  = '0;
    if (!tick.auto_enabled) begin
      st_next.mode             = uoa_pkg::M_FWD;
      st_next.mode_start_ms    = tick.now_ms;
      st_next.last_junction_ms = tick.now_ms;
    end else if (!fv) begin
      run.ents[0] = stop_e;
      run.cnt     = 2'd1;
    end else begin
      case (st.mode)
        uoa_pkg::M_FWD: begin
          run.cnt = 2'd1;
          if (front_c <= uoa_pkg::cmp_t'(cfg.fwd_stop_dist)) begin
            run.ents[0]           = stop_e;
            st_next.prefer_left   = choose_left;
            st_next.mode          = uoa_pkg::M_PAUSE;
            st_next.mode_start_ms = tick.now_ms;
          end else if (cool && lv && rv && (left_c >= uoa_pkg::cmp_t'(cfg.junc_open_dist)) &&
                       (left_c > fm) && (left_c > right_c)) begin
            run.ents[0]              = pl_e;
            st_next.mode             = uoa_pkg::M_PL;
            st_next.mode_start_ms    = tick.now_ms;
            st_next.last_junction_ms = tick.now_ms;
          end else if (cool && lv && rv && (right_c >= uoa_pkg::cmp_t'(cfg.junc_open_dist)) &&
                       (right_c > fm) && (right_c > left_c)) begin
            run.ents[0]              = pr_e;
            st_next.mode             = uoa_pkg::M_PR;
            st_next.mode_start_ms    = tick.now_ms;
            st_next.last_junction_ms = tick.now_ms;
          end else if (lv && rv) begin
            run.ents[0] = uoa_pkg::mk_ent(uoa_pkg::CMD_DIFF, dp + uoa_pkg::duty_t'(corr),
                                          dp - uoa_pkg::duty_t'(corr));
          end else begin
            run.ents[0] = uoa_pkg::mk_ent(uoa_pkg::CMD_FWD, dp, dp);
          end
        end
        uoa_pkg::M_PAUSE: begin
          run.ents[0] = stop_e;
          run.cnt     = 2'd1;
          if (el >= uoa_pkg::PAUSE_MS) begin
            run.cnt = 2'd2;
            if (lb && rb) begin
              run.ents[1]  = back_e;
              st_next.mode = uoa_pkg::M_REV;
            end else if (st.prefer_left) begin
              run.ents[1]  = pl_e;
              st_next.mode = uoa_pkg::M_PL;
            end else begin
              run.ents[1]  = pr_e;
              st_next.mode = uoa_pkg::M_PR;
            end
            st_next.mode_start_ms = tick.now_ms;
          end
        end
        uoa_pkg::M_REV: begin
          run.ents[0] = back_e;
          run.cnt     = 2'd1;
          if (el >= uoa_pkg::REVERSE_MS) begin
            run.cnt               = 2'd3;
            run.ents[1]           = stop_e;
            st_next.prefer_left   = choose_left;
            run.ents[2]           = choose_left ? pl_e : pr_e;
            st_next.mode          = choose_left ? uoa_pkg::M_PL : uoa_pkg::M_PR;
            st_next.mode_start_ms = tick.now_ms;
          end
        end
        uoa_pkg::M_PL, uoa_pkg::M_PR: begin
          run.ents[0] = (st.mode == uoa_pkg::M_PL) ? pl_e : pr_e;
          run.cnt     = 2'd1;
          if (turn_done) begin
            run.ents[1]              = stop_e;
            run.cnt                  = 2'd2;
            st_next.mode             = uoa_pkg::M_FWD;
            st_next.mode_start_ms    = tick.now_ms;
            st_next.last_junction_ms = tick.now_ms;
          end
        end
        default: begin
          run.ents[0]              = stop_e;
          run.cnt                  = 2'd1;
          st_next.mode             = uoa_pkg::M_FWD;
          st_next.mode_start_ms    = tick.now_ms;
          st_next.last_junction_ms = tick.now_ms;
        end
      endcase
    end
    run.mode = st_next.mode;
  end

endmodule
`default_nettype wire

/* rtl/uoa_outbuf.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uoa_outbuf - result register
// Holds one tick's commands and hands them out one per request.
// ----------------------------------------------------------------------------
module uoa_outbuf (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire uoa_pkg::run_t                 run_in,
  input  wire logic                          ready,
  output logic                               valid,
  output uoa_pkg::ent_t                      ent,
  output logic [uoa_pkg::MODE_W-1:0]         mode,
  output logic                               last,
  output logic                               free
);

  uoa_pkg::run_t            run;
  logic [uoa_pkg::CNT_W-1:0] idx;
  logic                      fire;

  assign fire = valid && ready;
  assign last = (idx == (run.cnt - 2'd1));
  assign free = !valid || (fire && last);
  assign mode = run.mode;

  always_comb begin
    case (idx)
      2'd0:    ent = run.ents[0];
      2'd1:    ent = run.ents[1];
      default: ent = run.ents[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else begin
      if (fire) begin
        if (last) begin
          valid <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      if (load) begin
        valid <= (run_in.cnt != 2'd0);
        idx   <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      run <= run_in;
    end
  end

endmodule
`default_nettype wire

/* rtl/ultrasonic_obstacle_avoid_fsm.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_obstacle_avoid_fsm - obstacle avoidance controller
// Turns control ticks with three distance readings into motor commands
// through a five-mode drive machine with wall-centering.
// ----------------------------------------------------------------------------
// path: a tick's first command is presented after its request is accepted,
//   through the input register, then the result register
// throughput: one tick per cycle while m_tready is high and no tick yields
//   more than one command; a longer run holds the result register to its last
// reset: synchronous; mode forward, both timers zero, prefer left, registers
//   at their defaults, both stream sides empty
module ultrasonic_obstacle_avoid_fsm (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // tick stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // now_ms, auto_enabled, front_mm, left_mm, right_mm, front_ok, left_ok,
  // right_ok, front_stamp_ms, left_stamp_ms, right_stamp_ms
  input  wire logic [uoa_pkg::IN_TDATA_W-1:0]    s_tdata,
  // motor command stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // motor_command, left_duty, right_duty, drive_mode, zero pad
  output logic [uoa_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                   m_tlast,
  // register writes
  input  wire logic                              cfg_we,
  input  wire logic [uoa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [uoa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  uoa_pkg::cfg_t   cfg;
  uoa_pkg::in_t    in_q;
  uoa_pkg::in_t    in_d;
  logic            in_valid;
  logic            take;
  logic            ob_free;
  uoa_pkg::state_t st;
  uoa_pkg::state_t st_next;
  uoa_pkg::run_t   run;
  uoa_pkg::ent_t   ent;
  logic [uoa_pkg::MODE_W-1:0] out_mode;

  uoa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // unpack the tick request
  assign in_d.now_ms         = s_tdata[uoa_pkg::OFS_NOW   +: uoa_pkg::TIME_W];
  assign in_d.auto_enabled   = s_tdata[uoa_pkg::OFS_AUTO];
  assign in_d.front_mm       = s_tdata[uoa_pkg::OFS_FRONT +: uoa_pkg::DIST_BITS];
  assign in_d.left_mm        = s_tdata[uoa_pkg::OFS_LEFT  +: uoa_pkg::DIST_BITS];
  assign in_d.right_mm       = s_tdata[uoa_pkg::OFS_RIGHT +: uoa_pkg::DIST_BITS];
  assign in_d.front_ok       = s_tdata[uoa_pkg::OFS_FOK];
  assign in_d.left_ok        = s_tdata[uoa_pkg::OFS_LOK];
  assign in_d.right_ok       = s_tdata[uoa_pkg::OFS_ROK];
  assign in_d.front_stamp_ms = s_tdata[uoa_pkg::OFS_FST   +: uoa_pkg::TIME_W];
  assign in_d.left_stamp_ms  = s_tdata[uoa_pkg::OFS_LST   +: uoa_pkg::TIME_W];
  assign in_d.right_stamp_ms = s_tdata[uoa_pkg::OFS_RST   +: uoa_pkg::TIME_W];

  // the held tick is processed once the result register can take its run;
  // a tick with no commands (auto off) only needs the same slot
  assign take     = in_valid && ob_free;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q <= in_d;
    end
  end

  // decision logic between input register and result register
  uoa_step u_step (
    .tick    (in_q),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .run     (run)
  );

  // drive machine state advances once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode             <= uoa_pkg::M_FWD;
      st.mode_start_ms    <= '0;
      st.last_junction_ms <= '0;
      st.prefer_left      <= 1'b1;
    end else if (take) begin
      st <= st_next;
    end
  end

  uoa_outbuf u_outbuf (
    .clk    (clk),
    .rst    (rst),
    .load   (take),
    .run_in (run),
    .ready  (m_tready),
    .valid  (m_tvalid),
    .ent    (ent),
    .mode   (out_mode),
    .last   (m_tlast),
    .free   (ob_free)
  );

  // pack the command, unused top bits stay zero
  always_comb begin
    m_tdata = '0;
    m_tdata[uoa_pkg::OFS_CMD   +: uoa_pkg::CMD_W]  = ent.cmd;
    m_tdata[uoa_pkg::OFS_LDUTY +: uoa_pkg::DUTY_W] = ent.left_duty;
    m_tdata[uoa_pkg::OFS_RDUTY +: uoa_pkg::DUTY_W] = ent.right_duty;
    m_tdata[uoa_pkg::OFS_MODE  +: uoa_pkg::MODE_W] = out_mode;
  end

  // an empty input register always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input register empty but not ready");

  // auto off returns to forward and restamps the mode timer
  a_auto_off: assert property (@(posedge clk) disable iff (rst)
    take && !in_q.auto_enabled |=>
      (st.mode == uoa_pkg::M_FWD) && (st.mode_start_ms == $past(in_q.now_ms)))
    else $error("auto off did not reset the drive machine");

  // a run is not cut short before its last command
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("command run ended without last");

  // every command of one run reports the same mode
  a_mode_steady: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tdata[uoa_pkg::OFS_MODE +: uoa_pkg::MODE_W] ==
      $past(m_tdata[uoa_pkg::OFS_MODE +: uoa_pkg::MODE_W]))
    else $error("drive mode changed inside a run");

endmodule
`default_nettype wire

/* sim/tb_ultrasonic_obstacle_avoid_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_obstacle_avoid_fsm - obstacle avoidance controller testbench
// Drives control ticks through the tick stream and checks every motor command
// against a cycle-free model of the five-mode drive machine. A directed run
// walks through mode changes at the default registers, then random ticks
// run under several register settings with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_ultrasonic_obstacle_avoid_fsm;
  import uoa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TICKS_PER_PHASE = 56;
  localparam int DIST_MAX = (1 << DIST_BITS) - 1;

  // one motor command as it should leave the block
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    duty_t             left_duty;
    duty_t             right_duty;
    logic [MODE_W-1:0] mode;
    logic              last;
  } motor_cmd_t;

  // model of the drive machine plus the queue of commands still to come
  class tick_scoreboard;
    cfg_t              regs;
    logic [MODE_W-1:0] mode;
    ms_t               mode_start;
    ms_t               last_junc;
    logic              prefer_left;
    motor_cmd_t        run_q[$];
    motor_cmd_t        want_q[$];
    int                errors;

    function new();
      regs.fwd_stop_dist      = rdist_t'(250);
      regs.fwd_clear_dist     = rdist_t'(400);
      regs.junc_open_dist     = rdist_t'(500);
      regs.side_block_dist    = rdist_t'(200);
      regs.junction_margin_mm = rdist_t'(200);
      regs.drive_pwm          = pwm_t'(500);
      regs.turn_pwm           = pwm_t'(500);
      regs.reverse_pwm        = pwm_t'(400);
      mode        = M_FWD;
      mode_start  = '0;
      last_junc   = '0;
      prefer_left = 1'b1;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_FRONT_STOP:   regs.fwd_stop_dist      = v;
        REG_FRONT_CLEAR:  regs.fwd_clear_dist     = v;
        REG_SIDE_OPEN:    regs.junc_open_dist     = v;
        REG_SIDE_BLOCKED: regs.side_block_dist    = v;
        REG_JUNC_MARGIN:  regs.junction_margin_mm = v;
        REG_DRIVE_PWM:    regs.drive_pwm          = v[PWM_W-1:0];
        REG_TURN_PWM:     regs.turn_pwm           = v[PWM_W-1:0];
        REG_REVERSE_PWM:  regs.reverse_pwm        = v[PWM_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_fresh(logic ok, ms_t stamp, ms_t now);
      ms_t age;
      age = now - stamp;
      return ok && (age <= STALE_MS);
    endfunction

    function logic pick_left(bit lv, bit rv, int l, int r);
      if (lv && rv) return (l >= r);
      return lv;
    endfunction

    function void issue(logic [CMD_W-1:0] cmd, int l, int r);
      motor_cmd_t e;
      e.cmd        = cmd;
      e.left_duty  = duty_t'(l);
      e.right_duty = duty_t'(r);
      e.mode       = '0;
      e.last       = 1'b0;
      run_q.push_back(e);
    endfunction

    // accepted tick: advance the model and queue the commands it causes
    function void note_tick(in_t t);
      bit  fv, lv, rv, cool, lb, rb;
      ms_t el, since_junc;
      int  f, l, r, err, corr, dp, tp, rp;
      f  = int'(t.front_mm);
      l  = int'(t.left_mm);
      r  = int'(t.right_mm);
      dp = int'(regs.drive_pwm);
      tp = int'(regs.turn_pwm);
      rp = int'(regs.reverse_pwm);
      run_q.delete();
      // auto off restamps both timers and says nothing
      if (!t.auto_enabled) begin
        mode       = M_FWD;
        mode_start = t.now_ms;
        last_junc  = t.now_ms;
        return;
      end
      fv = is_fresh(t.front_ok, t.front_stamp_ms, t.now_ms);
      lv = is_fresh(t.left_ok, t.left_stamp_ms, t.now_ms);
      rv = is_fresh(t.right_ok, t.right_stamp_ms, t.now_ms);
      if (!fv) begin
        // stale front: stop, state untouched
        issue(CMD_STOP, 0, 0);
      end else begin
        el = t.now_ms - mode_start;
        case (mode)
          M_FWD: begin
            since_junc = t.now_ms - last_junc;
            cool = (since_junc >= COOLDOWN_MS);
            if (f <= regs.fwd_stop_dist) begin
              issue(CMD_STOP, 0, 0);
              prefer_left = pick_left(lv, rv, l, r);
              mode        = M_PAUSE;
              mode_start  = t.now_ms;
            end else if (cool && lv && rv && l >= regs.junc_open_dist &&
                         l > f + regs.junction_margin_mm && l > r) begin
              issue(CMD_PL, tp, tp);
              mode       = M_PL;
              mode_start = t.now_ms;
              last_junc  = t.now_ms;
            end else if (cool && lv && rv && r >= regs.junc_open_dist &&
                         r > f + regs.junction_margin_mm && r > l) begin
              issue(CMD_PR, tp, tp);
              mode       = M_PR;
              mode_start = t.now_ms;
              last_junc  = t.now_ms;
            end else if (lv && rv) begin
              // wall-centering with deadband and clamp
              err  = r - l;
              corr = (err > DEADBAND_MM || err < -DEADBAND_MM) ? err : 0;
              if (corr > MAX_CORR) corr = MAX_CORR;
              else if (corr < -MAX_CORR) corr = -MAX_CORR;
              issue(CMD_DIFF, dp + corr, dp - corr);
            end else begin
              issue(CMD_FWD, dp, dp);
            end
          end
          M_PAUSE: begin
            issue(CMD_STOP, 0, 0);
            if (el >= PAUSE_MS) begin
              lb = !lv || (l < regs.side_block_dist);
              rb = !rv || (r < regs.side_block_dist);
              if (lb && rb) begin
                issue(CMD_BACK, rp, rp);
                mode = M_REV;
              end else if (prefer_left) begin
                issue(CMD_PL, tp, tp);
                mode = M_PL;
              end else begin
                issue(CMD_PR, tp, tp);
                mode = M_PR;
              end
              mode_start = t.now_ms;
            end
          end
          M_REV: begin
            issue(CMD_BACK, rp, rp);
            if (el >= REVERSE_MS) begin
              prefer_left = pick_left(lv, rv, l, r);
              issue(CMD_STOP, 0, 0);
              if (prefer_left) begin
                issue(CMD_PL, tp, tp);
                mode = M_PL;
              end else begin
                issue(CMD_PR, tp, tp);
                mode = M_PR;
              end
              mode_start = t.now_ms;
            end
          end
          M_PL, M_PR: begin
            issue((mode == M_PL) ? CMD_PL : CMD_PR, tp, tp);
            if ((el >= TURN_MIN_MS && f >= regs.fwd_clear_dist) || el >= TURN_MAX_MS) begin
              issue(CMD_STOP, 0, 0);
              mode       = M_FWD;
              mode_start = t.now_ms;
              last_junc  = t.now_ms;
            end
          end
          default: begin
            issue(CMD_STOP, 0, 0);
            mode       = M_FWD;
            mode_start = t.now_ms;
            last_junc  = t.now_ms;
          end
        endcase
      end
      // every command of the tick carries the final mode, the last one is flagged
      foreach (run_q[k]) begin
        run_q[k].mode = mode;
        run_q[k].last = (k == run_q.size() - 1);
        want_q.push_back(run_q[k]);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // accepted motor command against the oldest one queued
    function void check_cmd(logic [OUT_TDATA_W-1:0] d, logic last);
      motor_cmd_t want;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual %h last %b",
                 $time, d, last);
        errors++;
        return;
      end
      want = want_q.pop_front();
      compare_field("motor_command", int'(want.cmd), int'(d[OFS_CMD +: CMD_W]));
      compare_field("left_duty", int'(want.left_duty),
                    int'($signed(d[OFS_LDUTY +: DUTY_W])));
      compare_field("right_duty", int'(want.right_duty),
                    int'($signed(d[OFS_RDUTY +: DUTY_W])));
      compare_field("drive_mode", int'(want.mode), int'(d[OFS_MODE +: MODE_W]));
      compare_field("last_of_run", int'(want.last), int'(last));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // now_ms, auto_enabled, front_mm, left_mm, right_mm, front_ok, left_ok,
  // right_ok, front_stamp_ms, left_stamp_ms, right_stamp_ms
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // motor_command, left_duty, right_duty, drive_mode, zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  tick_scoreboard sb = new();
  ms_t tick_clock = '0;
  bit  calm = 1'b0;           // no idling on either side
  bit  long_hold_req = 1'b0;  // asks the command sink for a long stall
  int  cycles = 0;

  ultrasonic_obstacle_avoid_fsm dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // command sink: checks accepted commands and stalls in bursts
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_cmd(m_tdata, m_tlast);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // one tick request, with an optional idle burst in front of it
  task automatic send_tick(input in_t t);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(t);
    do @(posedge clk); while (!s_tready);
    sb.note_tick(t);
  endtask

  // directed tick: all three stamps share one age, ok is {right, left, front}
  task automatic step_tick(input ms_t dt, input bit auto_on, input int f, input int l,
                           input int r, input bit [2:0] ok, input ms_t age);
    in_t t;
    tick_clock += dt;
    t.now_ms         = tick_clock;
    t.auto_enabled   = auto_on;
    t.front_mm       = dist_t'(f);
    t.left_mm        = dist_t'(l);
    t.right_mm       = dist_t'(r);
    t.front_ok       = ok[0];
    t.left_ok        = ok[1];
    t.right_ok       = ok[2];
    t.front_stamp_ms = tick_clock - age;
    t.left_stamp_ms  = tick_clock - age;
    t.right_stamp_ms = tick_clock - age;
    send_tick(t);
  endtask

  function automatic dist_t pick_dist();
    case ($urandom_range(0, 6))
      0: return dist_t'($urandom_range(0, 300));
      1: return dist_t'($urandom_range(150, 700));
      2: return dist_t'($urandom_range(300, 1500));
      3: return '1;
      4: return '0;
      default: return dist_t'($urandom());
    endcase
  endfunction

  // reading age, mostly fresh, with the staleness edge and far-off stamps
  function automatic ms_t pick_age();
    case ($urandom_range(0, 11))
      0: return ms_t'($urandom_range(101, 400));
      1: return ms_t'($urandom());
      2: return STALE_MS;
      3: return STALE_MS + 1;
      default: return ms_t'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic in_t rand_tick();
    in_t t;
    int  v;
    case ($urandom_range(0, 39))
      0: ;  // same time as the last tick
      1, 2: tick_clock += $urandom_range(200, 2000);
      3: tick_clock = $urandom();
      default: tick_clock += $urandom_range(10, 60);
    endcase
    t.now_ms       = tick_clock;
    t.auto_enabled = ($urandom_range(0, 29) != 0);
    t.front_mm     = pick_dist();
    t.left_mm      = pick_dist();
    if ($urandom_range(0, 3) == 0) begin
      // right close to left to work the deadband
      v = int'(t.left_mm);
      v = v + int'($urandom_range(0, 40)) - 20;
      if (v < 0) v = 0;
      if (v > DIST_MAX) v = DIST_MAX;
      t.right_mm = dist_t'(v);
    end else begin
      t.right_mm = pick_dist();
    end
    t.front_ok       = ($urandom_range(0, 9) != 0);
    t.left_ok        = ($urandom_range(0, 9) != 0);
    t.right_ok       = ($urandom_range(0, 9) != 0);
    t.front_stamp_ms = tick_clock - pick_age();
    t.left_stamp_ms  = tick_clock - pick_age();
    t.right_stamp_ms = tick_clock - pick_age();
    return t;
  endfunction

  function automatic cfg_t flat_cfg(input rdist_t d, input pwm_t p);
    cfg_t c;
    c.fwd_stop_dist      = d;
    c.fwd_clear_dist     = d;
    c.junc_open_dist     = d;
    c.side_block_dist    = d;
    c.junction_margin_mm = d;
    c.drive_pwm          = p;
    c.turn_pwm           = p;
    c.reverse_pwm        = p;
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.fwd_stop_dist      = rdist_t'($urandom_range(0, 600));
    c.fwd_clear_dist     = rdist_t'($urandom_range(c.fwd_stop_dist, 1500));
    c.junc_open_dist     = rdist_t'($urandom_range(0, 1500));
    c.side_block_dist    = rdist_t'($urandom_range(0, 800));
    c.junction_margin_mm = rdist_t'($urandom_range(0, 600));
    c.drive_pwm          = pwm_t'($urandom_range(0, 1000));
    c.turn_pwm           = pwm_t'($urandom_range(0, 1000));
    c.reverse_pwm        = pwm_t'($urandom_range(0, 1000));
    return c;
  endfunction

  // write all eight registers, one per cycle
  task automatic load_regs(input cfg_t c);
    logic [CFG_DATA_W-1:0] vals [8];
    vals[REG_FRONT_STOP]   = c.fwd_stop_dist;
    vals[REG_FRONT_CLEAR]  = c.fwd_clear_dist;
    vals[REG_SIDE_OPEN]    = c.junc_open_dist;
    vals[REG_SIDE_BLOCKED] = c.side_block_dist;
    vals[REG_JUNC_MARGIN]  = c.junction_margin_mm;
    vals[REG_DRIVE_PWM]    = CFG_DATA_W'(c.drive_pwm);
    vals[REG_TURN_PWM]     = CFG_DATA_W'(c.turn_pwm);
    vals[REG_REVERSE_PWM]  = CFG_DATA_W'(c.reverse_pwm);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(CFG_ADDR_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // stop sending, wait for every queued command, then let silent ticks drain
  task automatic wait_idle(input int settle);
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (sb.want_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    cfg_t c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed walk at the reset register values, clock starts just before wrap
    tick_clock = 32'hFFFF_FF00;
    step_tick(0, 0, 1000, 1000, 1000, 3'b111, 0);              // auto off, no command
    step_tick(30, 1, 1000, 1000, 1000, 3'b110, 0);             // front flag low
    step_tick(30, 1, 1000, 1000, 1000, 3'b111, STALE_MS + 1);  // front just stale
    step_tick(30, 1, 4095, 1000, 1000, 3'b111, STALE_MS);      // oldest fresh reading
    step_tick(30, 1, 4095, 0, 4095, 3'b111, 0);                // correction clamps high
    step_tick(30, 1, 4095, 4095, 0, 3'b111, 0);                // correction clamps low
    step_tick(30, 1, 4095, 1000, 1015, 3'b111, 0);             // inside deadband
    step_tick(30, 1, 4095, 1000, 1016, 3'b111, 0);             // just outside deadband
    step_tick(30, 1, 4095, 1000, 1000, 3'b011, 0);             // one side stale, plain forward
    step_tick(1600, 1, 600, 900, 300, 3'b111, 0);              // open junction on the left
    step_tick(30, 1, 4095, 900, 300, 3'b111, 0);               // pivot under minimum time
    step_tick(300, 1, 4095, 900, 300, 3'b111, 0);              // front clear, back to forward
    step_tick(30, 1, 250, 100, 150, 3'b111, 0);                // front at stop distance
    step_tick(100, 1, 250, 100, 100, 3'b111, 0);               // still pausing
    step_tick(250, 1, 1000, 100, 100, 3'b111, 0);              // both sides blocked, reverse
    step_tick(100, 1, 1000, 300, 800, 3'b111, 0);              // reversing
    step_tick(500, 1, 1000, 300, 800, 3'b111, 0);              // reverse done, pivot right
    step_tick(1500, 1, 0, 300, 800, 3'b111, 0);                // turn time runs out
    step_tick(1600, 1, 600, 300, 900, 3'b111, 0);              // open junction on the right
    step_tick(400, 1, 400, 300, 900, 3'b111, 0);               // front exactly clear
    step_tick(30, 1, 0, 4095, 4095, 3'b111, 0);                // stop, equal sides prefer left
    step_tick(300, 1, 4095, 4095, 50, 3'b111, 0);              // pause done, pivot left
    step_tick(30, 0, 4095, 4095, 4095, 3'b111, 0);             // auto off mid-pivot

    // random ticks under several register settings, extremes first
    for (int p = 1; p <= 6; p++) begin
      wait_idle(4);
      case (p)
        1: c = flat_cfg('0, pwm_t'(1000));
        2: c = flat_cfg('1, '0);
        default: c = rand_cfg();
      endcase
      load_regs(c);
      if (p == 6) calm = 1'b1;
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        if (p == 3 && i == 20) long_hold_req = 1'b1;
        send_tick(rand_tick());
      end
    end

    wait_idle(10);
    if (sb.want_q.size() != 0) begin
      $display("%0t: commands missing, expected %0d more, actual 0",
               $time, sb.want_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
